// ===== hw/rtl/ccs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the circle center compass search block.
package ccs_pkg;

    localparam int CoordW  = 20;
    localparam int CfgW    = 14;
    localparam int ErrW    = 40;
    localparam int CenterW = 48;
    // Distance components stay below 2^31 for every step count up to 65536.
    localparam int DiffW   = 32;
    localparam int SqW     = 64;
    localparam int RootW   = 32;
    localparam int CostW   = 64;
    localparam logic [CostW-1:0] InitialPrev = 64'd99999;

    localparam logic [1:0] CfgRadius    = 2'd0;
    localparam logic [1:0] CfgStep      = 2'd1;
    localparam logic [1:0] CfgThreshold = 2'd2;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_START,
        ST_POINT,
        ST_SQUARE,
        ST_SQRT,
        ST_ACCUM,
        ST_DIVIDE,
        ST_COMPARE,
        ST_DECIDE,
        ST_OUTPUT
    } ccs_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       store_point;
        logic       search_init;
        logic       cand_init;
        logic       point_load;
        logic       square;
        logic       sqrt_step;
        logic       accum;
        logic       div_start;
        logic       div_step;
        logic       compare;
        logic       decide;
        logic       emit;
        logic       clear_cluster;
    } ccs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sqrt_done;
        logic last_pt;
        logic div_done;
        logic last_cand;
        logic stop;
        logic step_limit;
        logic out_busy;
    } ccs_status_t;

endpackage

// ===== hw/rtl/ccs_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: point store, distance, square root, accumulate, divide, search and result registers.
module ccs_datapath
    import ccs_pkg::*;
#(
    parameter int MAX_POINTS = 256,
    parameter int MAX_STEPS  = 1024
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  ccs_cmd_t                 cmd,
    output ccs_status_t              status,
    input  logic signed [CoordW-1:0] in_x,
    input  logic signed [CoordW-1:0] in_y,
    input  logic [CfgW-1:0]          radius,
    input  logic [CfgW-1:0]          step,
    input  logic [CfgW-1:0]          threshold,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [CoordW-1:0] center_x,
    output logic signed [CoordW-1:0] center_y,
    output logic [ErrW-1:0]          mean_sq_error,
    output logic                     hit_step_limit,
    output logic                     points_dropped
);

    localparam int AddrW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CountW = $clog2(MAX_POINTS + 1);
    localparam int StepsW = $clog2(MAX_STEPS + 1);
    localparam int SqrtIt = RootW;
    localparam int SqrtCW = $clog2(SqrtIt + 1);
    localparam int DivCW  = $clog2(CostW + 1);

    // Point store.
    logic signed [CoordW-1:0] mem_x [MAX_POINTS];
    logic signed [CoordW-1:0] mem_y [MAX_POINTS];
    logic signed [CoordW-1:0] rd_x_reg, rd_y_reg;
    logic [CountW-1:0] count_reg, count_next;
    logic              over_reg, over_next;
    logic [CountW-1:0] ptr_reg, ptr_next;

    logic full;
    assign full = (count_reg == CountW'(MAX_POINTS));

    // The read address is the next pointer, so the data is ready when the pointer is.
    always_ff @(posedge clk)
    begin
        if (cmd.store_point && !full)
        begin
            mem_x[count_reg[AddrW-1:0]] <= in_x;
            mem_y[count_reg[AddrW-1:0]] <= in_y;
        end
        rd_x_reg <= mem_x[ptr_next[AddrW-1:0]];
        rd_y_reg <= mem_y[ptr_next[AddrW-1:0]];
    end

    // Search state.
    logic signed [CenterW-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [CenterW-1:0] tx_reg, tx_next, ty_reg, ty_next;
    logic [2:0]        cand_reg, cand_next, best_reg, best_next;
    logic [CostW-1:0]  v_reg, v_next, prev_reg, prev_next;
    logic [StepsW-1:0] steps_reg, steps_next;
    logic              stop_reg, stop_next, limit_reg, limit_next;

    // Distance components, square distance and root.
    logic [DiffW-1:0]  ax_reg, ax_next, ay_reg, ay_next;
    logic [SqW-1:0]    n_reg, n_next;
    logic [SqW-1:0]    rem_reg, rem_next;
    logic [RootW-1:0]  root_reg, root_next;
    logic [SqrtCW-1:0] sqc_reg, sqc_next;
    logic [CostW-1:0]  sum_reg, sum_next;

    // Divider.
    logic [CostW-1:0]  q_reg, q_next;
    logic [CostW:0]    r_reg, r_next;
    logic [DivCW-1:0]  dvc_reg, dvc_next;

    // Result register.
    logic                     res_valid_reg, res_valid_next;
    logic signed [CoordW-1:0] res_x_reg, res_x_next, res_y_reg, res_y_next;
    logic [ErrW-1:0]          res_err_reg, res_err_next;
    logic                     res_limit_reg, res_limit_next;
    logic                     res_drop_reg, res_drop_next;

    logic signed [CenterW-1:0] st_s;
    assign st_s = CenterW'($signed({1'b0, step}));

    logic signed [CenterW-1:0] dx, dy;
    logic [DiffW-1:0] ax, ay;
    logic [SqW-1:0] sqx, sqy;
    logic [SqW-1:0] trial;
    logic [SqW-1:0] rem_sh;
    logic [RootW-1:0] e;
    logic [CostW-1:0] sq, sum_add;
    logic [CostW:0] r_sh;
    logic [CostW-1:0] diff, st2, th2;
    logic signed [CoordW-1:0] sat_x, sat_y;
    logic [ErrW-1:0] sat_err;

    always_comb
    begin
        dx = CenterW'(rd_x_reg) - tx_reg;
        dy = CenterW'(rd_y_reg) - ty_reg;
        ax = dx[CenterW-1] ? DiffW'(-dx) : DiffW'(dx);
        ay = dy[CenterW-1] ? DiffW'(-dy) : DiffW'(dy);
        // Both operands are 32 bits wide; the products fit the square width.
        sqx = SqW'(ax_reg) * SqW'(ax_reg);
        sqy = SqW'(ay_reg) * SqW'(ay_reg);
        rem_sh = {rem_reg[SqW-3:0], n_reg[SqW-1:SqW-2]};
        trial  = SqW'({root_reg, 2'b01});
        e = (root_reg >= RootW'(radius)) ? root_reg - RootW'(radius)
                                         : RootW'(radius) - root_reg;
        sq = CostW'(e) * CostW'(e);
        sum_add = (sum_reg > ~sq) ? {CostW{1'b1}} : sum_reg + sq;
        r_sh = {r_reg[CostW-1:0], q_reg[CostW-1]};
        diff = (v_reg >= prev_reg) ? v_reg - prev_reg : prev_reg - v_reg;
        st2 = CostW'(step) * CostW'(step);
        th2 = CostW'(threshold) * CostW'(threshold);
    end

    always_comb
    begin
        count_next = count_reg;
        over_next  = over_reg;
        ptr_next   = ptr_reg;
        cx_next = cx_reg; cy_next = cy_reg;
        tx_next = tx_reg; ty_next = ty_reg;
        cand_next = cand_reg; best_next = best_reg;
        v_next = v_reg; prev_next = prev_reg;
        steps_next = steps_reg; stop_next = stop_reg; limit_next = limit_reg;
        ax_next = ax_reg; ay_next = ay_reg;
        n_next = n_reg; rem_next = rem_reg; root_next = root_reg; sqc_next = sqc_reg;
        sum_next = sum_reg;
        q_next = q_reg; r_next = r_reg; dvc_next = dvc_reg;

        if (cmd.store_point)
        begin
            if (full)
                over_next = 1'b1;
            else
                count_next = count_reg + 1'b1;
        end
        if (cmd.search_init)
        begin
            cx_next = '0; cy_next = '0;
            prev_next = InitialPrev;
            steps_next = '0;
            stop_next = 1'b0;
            limit_next = 1'b1;
        end
        if (cmd.cand_init)
        begin
            tx_next = cx_reg + ((cand_reg == 3'd1) ? -st_s : (cand_reg == 3'd2) ? st_s : '0);
            ty_next = cy_reg + ((cand_reg == 3'd3) ? st_s : (cand_reg == 3'd4) ? -st_s : '0);
            ptr_next = '0;
            sum_next = '0;
        end
        if (cmd.point_load)
        begin
            // Registered read data gives the distance components.
            ax_next = ax;
            ay_next = ay;
        end
        if (cmd.square)
        begin
            n_next = sqx + sqy;
            rem_next = '0;
            root_next = '0;
            sqc_next = '0;
        end
        if (cmd.sqrt_step)
        begin
            // One result bit per cycle of the restoring root.
            n_next = {n_reg[SqW-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[RootW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[RootW-2:0], 1'b0};
            end
            sqc_next = sqc_reg + 1'b1;
        end
        if (cmd.accum)
        begin
            sum_next = sum_add;
            ptr_next = ptr_reg + 1'b1;
        end
        if (cmd.div_start)
        begin
            q_next = sum_reg;
            r_next = '0;
            dvc_next = '0;
        end
        if (cmd.div_step)
        begin
            // Restoring division, one quotient bit per cycle.
            if (r_sh >= (CostW+1)'(count_reg))
            begin
                r_next = r_sh - (CostW+1)'(count_reg);
                q_next = {q_reg[CostW-2:0], 1'b1};
            end
            else
            begin
                r_next = r_sh;
                q_next = {q_reg[CostW-2:0], 1'b0};
            end
            dvc_next = dvc_reg + 1'b1;
        end
        if (cmd.compare)
        begin
            if (cand_reg == 3'd0 || q_reg < v_reg)
            begin
                v_next = q_reg;
                best_next = cand_reg;
            end
            cand_next = (cand_reg == 3'd4) ? 3'd0 : cand_reg + 1'b1;
        end
        if (cmd.decide)
        begin
            if (diff < st2 || v_reg < th2)
            begin
                stop_next = 1'b1;
                limit_next = 1'b0;
            end
            else
            begin
                prev_next = v_reg;
                cx_next = cx_reg + ((best_reg == 3'd1) ? -st_s : (best_reg == 3'd2) ? st_s : '0);
                cy_next = cy_reg + ((best_reg == 3'd3) ? st_s : (best_reg == 3'd4) ? -st_s : '0);
                steps_next = steps_reg + 1'b1;
                if (best_reg == 3'd0)
                begin
                    stop_next = 1'b1;
                    limit_next = 1'b0;
                end
            end
        end
        if (cmd.clear_cluster)
        begin
            count_next = '0;
            over_next = 1'b0;
        end
    end

    // Saturated result values of the current search.
    always_comb
    begin
        if (cx_reg > CenterW'(524287))
            sat_x = 20'sh7FFFF;
        else if (cx_reg < -CenterW'(524288))
            sat_x = -20'sh80000;
        else
            sat_x = cx_reg[CoordW-1:0];
        if (cy_reg > CenterW'(524287))
            sat_y = 20'sh7FFFF;
        else if (cy_reg < -CenterW'(524288))
            sat_y = -20'sh80000;
        else
            sat_y = cy_reg[CoordW-1:0];
        sat_err = (v_reg > CostW'({ErrW{1'b1}})) ? {ErrW{1'b1}} : v_reg[ErrW-1:0];
    end

    // The result register holds one item until the receiver takes it.
    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_x_next     = res_x_reg;
        res_y_next     = res_y_reg;
        res_err_next   = res_err_reg;
        res_limit_next = res_limit_reg;
        res_drop_next  = res_drop_reg;
        if (res_valid_reg && out_ready)
            res_valid_next = 1'b0;
        if (cmd.emit)
        begin
            res_valid_next = 1'b1;
            res_x_next     = sat_x;
            res_y_next     = sat_y;
            res_err_next   = sat_err;
            res_limit_next = limit_reg;
            res_drop_next  = over_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            over_reg      <= 1'b0;
            cand_reg      <= '0;
            stop_reg      <= 1'b0;
            limit_reg     <= 1'b0;
            steps_reg     <= '0;
            dvc_reg       <= '0;
            res_valid_reg <= 1'b0;
            res_x_reg     <= '0;
            res_y_reg     <= '0;
            res_err_reg   <= '0;
            res_limit_reg <= 1'b0;
            res_drop_reg  <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            over_reg      <= over_next;
            cand_reg      <= cand_next;
            stop_reg      <= stop_next;
            limit_reg     <= limit_next;
            steps_reg     <= steps_next;
            dvc_reg       <= dvc_next;
            res_valid_reg <= res_valid_next;
            res_x_reg     <= res_x_next;
            res_y_reg     <= res_y_next;
            res_err_reg   <= res_err_next;
            res_limit_reg <= res_limit_next;
            res_drop_reg  <= res_drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        cx_reg <= cx_next; cy_reg <= cy_next;
        tx_reg <= tx_next; ty_reg <= ty_next;
        best_reg <= best_next;
        v_reg <= v_next; prev_reg <= prev_next;
        ax_reg <= ax_next; ay_reg <= ay_next;
        n_reg <= n_next; rem_reg <= rem_next; root_reg <= root_next; sqc_reg <= sqc_next;
        sum_reg <= sum_next;
        q_reg <= q_next; r_reg <= r_next;
    end

    always_comb
    begin
        status.sqrt_done  = (sqc_reg == SqrtCW'(SqrtIt - 1));
        status.last_pt    = (ptr_reg + 1'b1 >= count_reg);
        status.div_done   = (dvc_reg == DivCW'(CostW - 1));
        status.last_cand  = (cand_reg == 3'd4);
        status.stop       = stop_reg;
        status.step_limit = (steps_reg == StepsW'(MAX_STEPS));
        status.out_busy   = res_valid_reg && !out_ready;
    end

    // Result outputs.
    assign out_valid      = res_valid_reg;
    assign center_x       = res_x_reg;
    assign center_y       = res_y_reg;
    assign mean_sq_error  = res_err_reg;
    assign hit_step_limit = res_limit_reg;
    assign points_dropped = res_drop_reg;

endmodule

// ===== hw/rtl/ccs_control.sv =====
`timescale 1ns / 1ps
// Controller state machine sequencing load, cost evaluation and search steps.
module ccs_control
    import ccs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        in_last,
    input  ccs_status_t status,
    output ccs_cmd_t    cmd
);

    ccs_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_LOAD;
        else
            state_reg <= state_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:    if (in_valid && in_last) state_next = ST_START;
            ST_START:   state_next = ST_POINT;
            ST_POINT:   state_next = ST_SQUARE;
            ST_SQUARE:  state_next = ST_SQRT;
            ST_SQRT:    if (status.sqrt_done) state_next = ST_ACCUM;
            ST_ACCUM:   state_next = status.last_pt ? ST_DIVIDE : ST_POINT;
            ST_DIVIDE:  if (status.div_done) state_next = ST_COMPARE;
            ST_COMPARE: state_next = status.last_cand ? ST_DECIDE : ST_START;
            ST_DECIDE:  state_next = ST_OUTPUT;
            ST_OUTPUT:
            begin
                if (status.stop || status.step_limit)
                begin
                    if (!status.out_busy) state_next = ST_LOAD;
                end
                else
                    state_next = ST_START;
            end
            default:    state_next = ST_LOAD;
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                cmd.store_point = in_valid;
                cmd.search_init = in_valid && in_last;
            end
            ST_START:   cmd.cand_init = 1'b1;
            ST_POINT:   cmd.point_load = 1'b1;
            ST_SQUARE:  cmd.square = 1'b1;
            ST_SQRT:    cmd.sqrt_step = 1'b1;
            ST_ACCUM:   cmd.accum = 1'b1;
            ST_DIVIDE:  cmd.div_step = 1'b1;
            ST_COMPARE: cmd.compare = 1'b1;
            ST_DECIDE:  cmd.decide = 1'b1;
            ST_OUTPUT:
            begin
                cmd.emit = (status.stop || status.step_limit) && !status.out_busy;
                cmd.clear_cluster = cmd.emit;
            end
            default:    cmd = '0;
        endcase
    end

endmodule

// ===== hw/rtl/ccs_divstart.sv =====
`timescale 1ns / 1ps
// Delays the divider load to the cycle after the final accumulate, so it sees the final accumulated sum.
module ccs_divstart
    import ccs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  ccs_cmd_t cmd_in,
    input  logic     last_pt,
    output ccs_cmd_t cmd_out
);

    logic pend_reg, pend_next;

    assign pend_next = cmd_in.accum && last_pt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 1'b0;
        else
            pend_reg <= pend_next;
    end

    // The first divide cycle only loads; steps follow after it.
    always_comb
    begin
        cmd_out = cmd_in;
        cmd_out.div_start = pend_reg;
        cmd_out.div_step  = cmd_in.div_step && !pend_reg;
    end

endmodule

// ===== hw/rtl/circle_center_compass_search_top.sv =====
`timescale 1ns / 1ps
// Loading takes one cycle per point item; the fit starts on the item marked last.
// Each candidate loads, squares, roots bit-serially and accumulates every point,
// then divides the sum bit-serially. A search step is 5 candidates plus a decide
// and an output state; the result is valid after the last search step.
// One result register lets the next cluster load while a result waits.
// Asynchronous active-low reset empties the point store and restores config defaults.
module circle_center_compass_search_top
    import ccs_pkg::*;
#(
    parameter int MAX_POINTS = 256,
    parameter int MAX_STEPS  = 1024
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [CfgW-1:0]          cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [CoordW-1:0] point_x,
    input  logic signed [CoordW-1:0] point_y,
    input  logic                     last_point,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [CoordW-1:0] center_x,
    output logic signed [CoordW-1:0] center_y,
    output logic [ErrW-1:0]          mean_sq_error,
    output logic                     hit_step_limit,
    output logic                     points_dropped
);

    logic [CfgW-1:0] radius_reg, step_reg, thresh_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 14'd250;
            step_reg   <= 14'd10;
            thresh_reg <= 14'd5;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CfgRadius:    radius_reg <= cfg_data;
                CfgStep:      step_reg   <= cfg_data;
                CfgThreshold: thresh_reg <= cfg_data;
                default:      radius_reg <= radius_reg;
            endcase
        end
    end

    ccs_cmd_t    cmd_raw, cmd;
    ccs_status_t status;

    ccs_control u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_last   (last_point),
        .status    (status),
        .cmd       (cmd_raw)
    );

    ccs_divstart u_dstart (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd_in  (cmd_raw),
        .last_pt (status.last_pt),
        .cmd_out (cmd)
    );

    ccs_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_STEPS  (MAX_STEPS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_x           (point_x),
        .in_y           (point_y),
        .radius         (radius_reg),
        .step           (step_reg),
        .threshold      (thresh_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .center_x       (center_x),
        .center_y       (center_y),
        .mean_sq_error  (mean_sq_error),
        .hit_step_limit (hit_step_limit),
        .points_dropped (points_dropped)
    );

endmodule
